// File: rtl/sxd_pkg.sv
// Shared types and constants for the sprite XOR draw block.
package sxd_pkg;

  localparam int DEF_SCREEN_WIDTH  = 64;
  localparam int DEF_SCREEN_HEIGHT = 32;

  localparam int PIX_W    = 64;  // width of the row pixel field
  localparam int SPR_W    = 8;   // pixels in one sprite row
  localparam int COORD_W  = 8;   // raw X and Y register width
  localparam int IDX_W    = 4;   // sprite row offset width
  localparam int IN_DATA_W = 32; // packed input payload, byte aligned

  localparam logic [2:0] SPR_MSB = 3'h7;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } sxd_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } sxd_state_t;

  typedef struct packed {
    logic capture;  // latch the beat and launch the framebuffer read
    logic commit;   // write back, update flag, load result register
  } sxd_cmd_t;

  typedef struct packed {
    logic slot_free;  // result register empty or being drained
  } sxd_status_t;

endpackage

// File: rtl/sxd_ctrl.sv
// Controller state machine: sequences capture and read-modify-write commit.
module sxd_ctrl
  import sxd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  sxd_status_t status,
  output sxd_cmd_t    cmd
);

  sxd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take the beat
        if (status.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/sxd_datapath.sv
// Datapath: framebuffer memory, sprite mask, collision flag and result register.
module sxd_datapath
  import sxd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sxd_cmd_t           cmd,
  output sxd_status_t        status,
  input  sxd_op_t            opcode,
  input  logic [COORD_W-1:0] x_value,
  input  logic [COORD_W-1:0] y_value,
  input  logic [IDX_W-1:0]   row_index,
  input  logic [SPR_W-1:0]   sprite_row,
  input  logic               first_row,
  input  logic               last_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_collision,
  output logic               out_sprite_done,
  output logic [PIX_W-1:0]   out_row_pixels
);

  localparam int CW   = $clog2(SCREEN_WIDTH);
  localparam int AW   = $clog2(SCREEN_HEIGHT);
  localparam int SW   = AW + 1;
  localparam int MW   = SCREEN_WIDTH + SPR_W;
  localparam int LUTN = 2 ** COORD_W;

  // constant tables for the modulo reductions
  logic [CW-1:0] xmod_lut [LUTN];
  logic [AW-1:0] ymod_lut [LUTN];

  for (genvar i = 0; i < LUTN; i++) begin : g_lut
    assign xmod_lut[i] = CW'(i % SCREEN_WIDTH);
    assign ymod_lut[i] = AW'(i % SCREEN_HEIGHT);
  end

  logic [SCREEN_WIDTH-1:0]  mem [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] row_valid_r;

  sxd_op_t                 op_r;
  logic [SCREEN_WIDTH-1:0] mask_r;
  logic [AW-1:0]           addr_r;
  logic                    clip_r;
  logic                    first_r;
  logic                    last_r;
  logic [SCREEN_WIDTH-1:0] rd_data_r;
  logic                    rd_valid_r;

  logic                    flag_r, flag_nxt;
  logic                    out_valid_r;
  logic                    out_collision_r;
  logic                    out_done_r;
  logic [PIX_W-1:0]        out_pix_r;

  // capture-side logic
  logic [CW-1:0]           xmod;
  logic [AW-1:0]           ymod;
  logic [SW-1:0]           row_sum;
  logic                    clip;
  logic [AW-1:0]           rd_addr;
  logic [SPR_W-1:0]        rev;
  logic [MW-1:0]           mask_wide;
  logic [SCREEN_WIDTH-1:0] mask_nxt;

  always_comb begin
    xmod    = xmod_lut[x_value];
    ymod    = ymod_lut[y_value];
    row_sum = SW'(ymod) + SW'(row_index);
    clip    = (row_sum >= SW'(SCREEN_HEIGHT));
    if (opcode == OP_READ) begin
      rd_addr = ymod;
    end else if (clip) begin
      rd_addr = '0;
    end else begin
      rd_addr = row_sum[AW-1:0];
    end
    // sprite MSB is the leftmost pixel, i.e. the lowest column
    for (int b = 0; b < SPR_W; b++) begin
      rev[b] = sprite_row[3'(SPR_MSB - 3'(b))];
    end
    mask_wide = MW'(rev) << xmod;
    mask_nxt  = clip ? '0 : mask_wide[SCREEN_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= opcode;
      mask_r     <= mask_nxt;
      addr_r     <= rd_addr;
      clip_r     <= clip;
      first_r    <= first_row;
      last_r     <= last_row;
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= row_valid_r[rd_addr];
    end
  end

  // execute-side logic
  logic [SCREEN_WIDTH-1:0] cur_row;
  logic [SCREEN_WIDTH-1:0] new_row;
  logic                    hit;
  logic                    wr_en;
  logic                    done_nxt;
  logic [PIX_W-1:0]        pix_nxt;

  always_comb begin
    cur_row  = rd_valid_r ? rd_data_r : '0;
    new_row  = cur_row ^ mask_r;
    hit      = |(cur_row & mask_r);
    flag_nxt = flag_r;
    done_nxt = 1'b0;
    pix_nxt  = '0;
    wr_en    = 1'b0;
    unique case (op_r)
      OP_DRAW: begin
        flag_nxt = (flag_r & ~first_r) | hit;
        done_nxt = last_r;
        wr_en    = ~clip_r;
      end
      OP_READ:  pix_nxt = PIX_W'(cur_row);
      OP_CLEAR: begin
        flag_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      OP_NOP:   flag_nxt = flag_r;
      default:  flag_nxt = flag_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[addr_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit && wr_en) begin
        row_valid_r[addr_r] <= 1'b1;
      end
      if (cmd.commit) begin
        flag_r      <= flag_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_collision_r <= flag_nxt;
      out_done_r      <= done_nxt;
      out_pix_r       <= pix_nxt;
    end
  end

  assign status.slot_free = ~out_valid_r | out_ready;
  assign out_valid        = out_valid_r;
  assign out_collision    = out_collision_r;
  assign out_sprite_done  = out_done_r;
  assign out_row_pixels   = out_pix_r;

endmodule

// File: rtl/sprite_xor_draw_collision.sv
// Path: an accepted input beat is latched into the capture registers and is then
//   committed to the output register, later while a stalled result still holds it.
// The next input beat is not accepted until the current item commits; the
//   read-modify-write of one framebuffer row uses a single memory port with registered read data.
// A result waiting in the output register does not block the next accept.
// Reset: synchronous, active low; per-row valid bits blank the whole
//   framebuffer at once, the collision flag and the result register clear.
module sprite_xor_draw_collision
  import sxd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // x_value, y_value, row_index, sprite_row, pad
  input  logic [2:0]           in_tuser,   // opcode, first_row
  input  logic                 in_tlast,   // last_row
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,  // row_pixels
  output logic                 out_tuser,  // collision
  output logic                 out_tlast   // sprite_done
);

  sxd_cmd_t    cmd;
  sxd_status_t status;

  sxd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sxd_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .opcode          (sxd_op_t'(in_tuser[1:0])),
    .x_value         (in_tdata[7:0]),
    .y_value         (in_tdata[15:8]),
    .row_index       (in_tdata[19:16]),
    .sprite_row      (in_tdata[27:20]),
    .first_row       (in_tuser[2]),
    .last_row        (in_tlast),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_collision   (out_tuser),
    .out_sprite_done (out_tlast),
    .out_row_pixels  (out_tdata)
  );

endmodule

// File: rtl/sxd_checker.sv
// Port-level checks for the sprite draw block, bound to the top level.
module sxd_checker
  import sxd_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [PIX_W-1:0]     out_tdata,
  input logic                 out_tuser,
  input logic                 out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // an accepted item keeps the input side busy in its execute state
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // a new result only follows an item that was in work
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without an item in work");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind sprite_xor_draw_collision sxd_checker u_sxd_checker (.*);
